// ===== sv/rfaf_pkg.sv =====
`default_nettype none
// ============================================================================
// rfaf_pkg
// Shared types, constants and the base64 decode for the radio frame
// address filter.
// ============================================================================
package rfaf_pkg;

    // Frame layout and limits.
    localparam int unsigned MAX_FRAME_BYTES = 100;
    localparam int unsigned MAX_ALIASES     = 6;
    localparam int unsigned NUM_ALIAS_REGS  = 6;

    localparam int unsigned COUNT_W = 7;

    localparam logic [COUNT_W-1:0] FRAME_MAX    = COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] DEST_FIRST   = 7'd1;
    localparam logic [COUNT_W-1:0] DEST_LAST    = 7'd4;
    localparam logic [COUNT_W-1:0] SRC_FIRST    = 7'd5;
    localparam logic [COUNT_W-1:0] SRC_LAST     = 7'd8;
    localparam logic [COUNT_W-1:0] LEN_HI_POS   = 7'd9;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 7'd10;

    localparam logic [15:0] SLASH_PAIR = 16'h2F2F;

    // Configuration register indexes.
    localparam logic [2:0] REG_ALIAS_COUNT  = 3'd0;
    localparam logic [2:0] REG_ALIAS_WORD_0 = 3'd1;

    // Frame status codes.
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_LENGTH   = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    // Address kinds.
    localparam logic [1:0] KIND_BROADCAST = 2'd0;
    localparam logic [1:0] KIND_MULTICAST = 2'd1;
    localparam logic [1:0] KIND_UNICAST   = 2'd2;

    typedef logic [NUM_ALIAS_REGS-1:0][31:0] alias_array_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] kind;
    } filter_result_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [1:0]  address_kind;
        logic [31:0] source_address;
        logic [31:0] dest_address;
    } result_t;

    // Characters outside the base64 alphabet decode as zero.
    function automatic logic [5:0] b64_value(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c inside {[8'h41:8'h5A]}) v = 6'(c - 8'h41);
        else if (c inside {[8'h61:8'h7A]}) v = 6'(c - 8'h61 + 8'd26);
        else if (c inside {[8'h30:8'h39]}) v = 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) v = 6'd62;
        else if (c == 8'h2F) v = 6'd63;
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/rfaf_dest_filter.sv =====
`default_nettype none
// ============================================================================
// rfaf_dest_filter
// Classifies a complete destination word and matches it against the
// configured aliases, all comparisons in parallel.
// ============================================================================
module rfaf_dest_filter (
    input  wire logic [31:0]           dest_word,
    input  wire logic [2:0]            alias_count,
    input  wire rfaf_pkg::alias_array_t alias_words,
    output rfaf_pkg::filter_result_t   result
);
    import rfaf_pkg::*;

    logic [2:0]                n_used;
    logic [NUM_ALIAS_REGS-1:0] uni_hit;
    logic [NUM_ALIAS_REGS-1:0] multi_hit;

    // Counts above the supported number of aliases use them all.
    assign n_used = (32'(alias_count) > MAX_ALIASES) ? 3'(MAX_ALIASES) : alias_count;

    always_comb
    begin
        for (int i = 0; i < NUM_ALIAS_REGS; i++)
        begin
            uni_hit[i]   = (3'(i) < n_used) && (alias_words[i] == dest_word);
            multi_hit[i] = (3'(i) < n_used) && (alias_words[i][31:16] == dest_word[15:0]);
        end
    end

    always_comb
    begin
        if (dest_word[31:16] == SLASH_PAIR)
        begin
            if (dest_word[15:0] == SLASH_PAIR)
            begin
                result.kind = KIND_BROADCAST;
                result.ok   = 1'b1;
            end
            else
            begin
                result.kind = KIND_MULTICAST;
                result.ok   = |multi_hit;
            end
        end
        else
        begin
            result.kind = KIND_UNICAST;
            result.ok   = |uni_hit;
        end
    end

endmodule
`default_nettype wire

// ===== sv/radio_frame_address_filter.sv =====
`default_nettype none
// ============================================================================
// radio_frame_address_filter
// Byte-wide receive filter: header capture, destination filtering, payload
// streaming and end-of-frame status.
// ============================================================================
// The block takes one frame byte per clock cycle while its skid entry is
// empty, whatever the frame content. Each word is handled in a single pass of
// logic between the frame state registers and the output register; the
// comparisons against the six aliases run in parallel within it. A result
// is registered, in the output register or else the skid entry, when its
// byte is accepted. An output register backed by one skid entry decouples
// the two sides, so in_ready depends only on that skid entry and never on
// out_ready directly. Bytes that yield no result (header bytes and payload
// of a rejected frame, unless last in the frame) are absorbed silently.
// ============================================================================
module radio_frame_address_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input channel.
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        rx_last,
    // Output channel.
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             frame_end,
    output logic [1:0]       frame_status,
    output logic [1:0]       address_kind,
    output logic [31:0]      source_address,
    output logic [31:0]      dest_address
);
    import rfaf_pkg::*;

    // Configuration.
    logic [2:0]   alias_count_reg;
    alias_array_t alias_words_reg;

    // Frame state.
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [31:0]        dest_word_reg, dest_word_next;
    logic [31:0]        source_word_reg, source_word_next;
    logic [11:0]        length_bits_reg, length_bits_next;
    logic               address_ok_reg, address_ok_next;
    logic [1:0]         kind_reg, kind_next;
    logic               overflow_reg, overflow_next;

    // Output stage.
    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;

    logic               accept;
    logic               full;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] payload_count;
    logic [11:0]        expected_bits;
    logic               produce;
    logic               push, pop;
    result_t            new_result;
    filter_result_t     filt;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alias_count_reg <= 3'd0;
            alias_words_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_ALIAS_COUNT)
                alias_count_reg <= cfg_data[2:0];
            else if (32'(cfg_index) >= 32'(REG_ALIAS_WORD_0) &&
                     32'(cfg_index) < 32'(REG_ALIAS_WORD_0) + NUM_ALIAS_REGS)
                alias_words_reg[3'(cfg_index - REG_ALIAS_WORD_0)] <= cfg_data;
        end
    end

    rfaf_dest_filter u_dest_filter (
        .dest_word   (dest_word_next),
        .alias_count (alias_count_reg),
        .alias_words (alias_words_reg),
        .result      (filt)
    );

    // ------------------------------------------------------------------
    // Per-byte frame processing
    // ------------------------------------------------------------------
    always_comb
    begin
        full             = (byte_count_reg >= FRAME_MAX);
        byte_count_next  = full ? byte_count_reg : byte_count_reg + 7'd1;
        pos              = full ? 7'd0 : byte_count_next;
        overflow_next    = overflow_reg | full;
        dest_word_next   = dest_word_reg;
        source_word_next = source_word_reg;
        length_bits_next = length_bits_reg;
        address_ok_next  = address_ok_reg;
        kind_next        = kind_reg;
        new_result.byte_valid = 1'b0;

        if (pos inside {[DEST_FIRST:DEST_LAST]})
        begin
            dest_word_next = {dest_word_reg[23:0], rx_byte};
            if (pos == DEST_LAST)
            begin
                address_ok_next = filt.ok;
                kind_next       = filt.kind;
            end
        end
        else if (pos inside {[SRC_FIRST:SRC_LAST]})
            source_word_next = {source_word_reg[23:0], rx_byte};
        else if (pos == LEN_HI_POS)
            length_bits_next = {b64_value(rx_byte), 6'd0};
        else if (pos == HEADER_BYTES)
            length_bits_next = length_bits_reg + {6'd0, b64_value(rx_byte)};
        else if (pos > HEADER_BYTES)
            new_result.byte_valid = address_ok_reg;

        // Payload bytes counted so far, only meaningful once the header is in.
        payload_count = byte_count_next - HEADER_BYTES;
        expected_bits = {2'b00, payload_count, 3'b000};

        if (!rx_last)
            new_result.frame_status = STATUS_ACCEPTED;
        else if (byte_count_next < DEST_LAST)
            new_result.frame_status = STATUS_LENGTH;
        else if (!address_ok_next)
            new_result.frame_status = STATUS_REJECTED;
        else if (overflow_next)
            new_result.frame_status = STATUS_TOO_LONG;
        else if (byte_count_next < HEADER_BYTES || length_bits_next != expected_bits)
            new_result.frame_status = STATUS_LENGTH;
        else
            new_result.frame_status = STATUS_ACCEPTED;

        new_result.payload_byte   = new_result.byte_valid ? rx_byte : 8'd0;
        new_result.frame_end      = rx_last;
        new_result.address_kind   = kind_next;
        new_result.source_address = source_word_next;
        new_result.dest_address   = dest_word_next;

        produce = new_result.byte_valid || rx_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            dest_word_reg   <= '0;
            source_word_reg <= '0;
            length_bits_reg <= '0;
            address_ok_reg  <= 1'b0;
            kind_reg        <= KIND_BROADCAST;
            overflow_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (rx_last)
            begin
                // The final byte closes the frame; start the next one clean.
                byte_count_reg  <= '0;
                dest_word_reg   <= '0;
                source_word_reg <= '0;
                length_bits_reg <= '0;
                address_ok_reg  <= 1'b0;
                kind_reg        <= KIND_BROADCAST;
                overflow_reg    <= 1'b0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                dest_word_reg   <= dest_word_next;
                source_word_reg <= source_word_next;
                length_bits_reg <= length_bits_next;
                address_ok_reg  <= address_ok_next;
                kind_reg        <= kind_next;
                overflow_reg    <= overflow_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    assign push = accept && produce;
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_data_reg <= new_result;
            else
                skid_data_reg <= new_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = out_data_reg.payload_byte;
    assign byte_valid     = out_data_reg.byte_valid;
    assign frame_end      = out_data_reg.frame_end;
    assign frame_status   = out_data_reg.frame_status;
    assign address_kind   = out_data_reg.address_kind;
    assign source_address = out_data_reg.source_address;
    assign dest_address   = out_data_reg.dest_address;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= FRAME_MAX)
        else $error("byte count ran past the frame limit");

    a_overflow_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (byte_count_reg == FRAME_MAX))
        else $error("overflow flagged before the frame limit was reached");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx_last) |=> (byte_count_reg == '0 && !overflow_reg && !address_ok_reg))
        else $error("frame state not cleared after the final byte");

    a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx_last) |=> out_valid_reg)
        else $error("final byte produced no output word");

endmodule
`default_nettype wire
